>>> hw/rtl/imu_motion_event_classifier_assert.svh
// Assertion macros shared by the block's checker.
`ifndef IMU_MOTION_EVENT_CLASSIFIER_ASSERT_SVH
`define IMU_MOTION_EVENT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define IMEC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("imec assertion failed");

// Next-cycle implication, disabled while reset is held.
`define IMEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("imec assertion failed");

// Next-cycle implication that also covers reset itself.
`define IMEC_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("imec reset assertion failed");

`endif

>>> hw/rtl/imec_pkg.sv
// ----------------------------------------------------------------------------
// imec_pkg
// Types, constants and tables of the motion event classifier.
// ----------------------------------------------------------------------------
package imec_pkg;

    localparam int unsigned CFG_W     = 17;
    localparam int unsigned CORDIC_W  = 27;
    localparam int unsigned ANGLE_W   = 16;
    localparam int unsigned Z_W       = 23;

    localparam logic [31:0] SHAKE_HOLD_MS   = 32'd500;
    localparam logic [31:0] FURIOUS_HOLD_MS = 32'd500;
    localparam logic [31:0] TAP_GAP_MS      = 32'd300;

    localparam logic signed [16:0] ONE_G      = 17'sd4096;
    localparam logic [16:0]        ACCEL_GATE = 17'd82;
    localparam logic [16:0]        RATE_GATE  = 17'd80;
    localparam logic [7:0]         RATE_COEF  = 8'd77;
    localparam logic [15:0]        MOVE_RATE  = 16'd640;
    localparam logic signed [Z_W-1:0] DEG180  = 23'sd737280;

    localparam logic [11:0] TILT_LIMIT_RST   = 12'd320;
    localparam logic [15:0] ANGRY_RATE_RST   = 16'd3200;
    localparam logic [15:0] FURIOUS_RATE_RST = 16'd4480;
    localparam logic [16:0] TAP_LIMIT_RST    = 17'd2048;
    localparam logic [14:0] STILL_LIMIT_RST  = 15'd246;
    localparam logic [14:0] VERT_TOL_RST     = 15'd492;
    localparam logic [7:0]  SMOOTHING_RST    = 8'd51;
    localparam logic [15:0] TICK_PERIOD_RST  = 16'd10;

    typedef enum logic [2:0] {
        REG_TILT_LIMIT   = 3'd0,
        REG_ANGRY_RATE   = 3'd1,
        REG_FURIOUS_RATE = 3'd2,
        REG_TAP_LIMIT    = 3'd3,
        REG_STILL_LIMIT  = 3'd4,
        REG_VERT_TOL     = 3'd5,
        REG_SMOOTHING    = 3'd6,
        REG_TICK_PERIOD  = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        EVT_NONE    = 3'd0,
        EVT_FURIOUS = 3'd1,
        EVT_SHAKE   = 3'd2,
        EVT_TAP     = 3'd3,
        EVT_TILT    = 3'd4,
        EVT_STILL   = 3'd5
    } evt_t;

    // Arctangent of 2^-i in 1/4096 degree.
    function automatic logic [17:0] arc_of(input logic [3:0] i);
        logic [17:0] r;
        case (i)
            4'd0:    r = 18'd184320;
            4'd1:    r = 18'd108810;
            4'd2:    r = 18'd57492;
            4'd3:    r = 18'd29184;
            4'd4:    r = 18'd14649;
            4'd5:    r = 18'd7331;
            4'd6:    r = 18'd3667;
            4'd7:    r = 18'd1833;
            4'd8:    r = 18'd917;
            4'd9:    r = 18'd458;
            4'd10:   r = 18'd229;
            4'd11:   r = 18'd115;
            4'd12:   r = 18'd57;
            4'd13:   r = 18'd29;
            4'd14:   r = 18'd14;
            default: r = 18'd7;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] abs17(input logic signed [16:0] v);
        return v[16] ? 17'(-v) : 17'(v);
    endfunction

endpackage

>>> hw/rtl/imu_motion_event_classifier.sv
// ----------------------------------------------------------------------------
// imu_motion_event_classifier
// Filters IMU samples and classifies each one into a single motion event.
// ----------------------------------------------------------------------------
// Each transaction on the s_ channel is one timestamped accel/gyro sample or a
// clear command, and gives exactly one m_ transaction holding the event code
// and the filter state after that step. The block takes one transaction at a
// time. Its run time is set by the shared 17x17 multiplier used for the
// squares and filter products, the 16-step square root unit run once or twice,
// and the 16-step CORDIC unit run twice (pitch, then roll) for a sample that
// reaches the tilt test; a clear or a too-early sample uses none of them. A
// finished result sits in the output register, so the next transaction is
// taken while it still waits for m_ready. The user must write configuration
// through cfg_we / cfg_index / cfg_wdata only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module imu_motion_event_classifier (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [imec_pkg::CFG_W-1:0] cfg_wdata,
    // sample channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [31:0]                s_time_ms,
    input  logic signed [15:0]         s_accel_x,
    input  logic signed [15:0]         s_accel_y,
    input  logic signed [15:0]         s_accel_z,
    input  logic signed [15:0]         s_rate_x,
    input  logic signed [15:0]         s_rate_y,
    input  logic signed [15:0]         s_rate_z,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_event_res,
    output logic signed [15:0]         m_smooth_x,
    output logic signed [15:0]         m_smooth_y,
    output logic signed [15:0]         m_smooth_z,
    output logic [15:0]                m_smooth_rate
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_GSTART,
        ST_GROOT,
        ST_F_MUL,
        ST_F_UPD,
        ST_DECIDE,
        ST_P_MUL,
        ST_P_ACC,
        ST_PSTART,
        ST_PROOT,
        ST_PITCH_GO,
        ST_PITCH,
        ST_ROLL_GO,
        ST_ROLL,
        ST_TILT,
        ST_FIN
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [11:0] tilt_limit_reg;
    logic [15:0] angry_rate_reg;
    logic [15:0] furious_rate_reg;
    logic [16:0] tap_limit_reg;
    logic [14:0] still_limit_reg;
    logic [14:0] vert_tol_reg;
    logic [7:0]  smoothing_reg;
    logic [15:0] tick_period_reg;

    // filter and event state
    logic signed [15:0] fax_reg, fay_reg, faz_reg;
    logic [15:0]        frate_reg;
    logic               shake_active_reg, furious_active_reg;
    logic [31:0]        shake_begin_reg, furious_begin_reg;
    logic [31:0]        last_sample_reg, last_tap_reg;

    // captured sample
    logic [31:0]        time_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;

    // working registers
    logic [1:0]         idx_reg;
    logic [31:0]        acc_reg;
    logic [15:0]        gmag_reg;
    logic               moving_reg;
    logic signed [imec_pkg::ANGLE_W-1:0] pitch_reg, roll_reg;
    logic [2:0]         evt_reg;

    // output register
    logic               out_valid_reg;
    logic [2:0]         out_evt_reg;
    logic signed [15:0] out_x_reg, out_y_reg, out_z_reg;
    logic [15:0]        out_rate_reg;

    // shared multiplier
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod_next, prod_reg;

    // filter datapath
    logic signed [16:0] cur_ext, filt_ext, diff;
    logic [16:0]        gate;
    logic [7:0]         coef;
    logic signed [33:0] prod_adj, prod_q;
    logic signed [16:0] filt_new;
    logic               gate_open;

    // decision datapath
    logic [16:0]        abs_ax, abs_ay, abs_dz;
    logic [17:0]        tap_mag;
    logic               moving;
    logic [31:0]        since_sample, since_furious, since_shake, since_tap;
    logic [imec_pkg::ANGLE_W-1:0] abs_pitch, abs_roll;

    // shared units
    logic        sqrt_start, sqrt_done;
    logic [15:0] sqrt_root;
    logic        cordic_start, cordic_done;
    logic signed [imec_pkg::CORDIC_W-1:0] cordic_y, cordic_x;
    logic signed [imec_pkg::ANGLE_W-1:0]  cordic_angle;

    // ---------------- operand selection for the shared multiplier -----------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_MUL: begin
                case (idx_reg)
                    2'd0:    mul_a = 17'(gx_reg);
                    2'd1:    mul_a = 17'(gy_reg);
                    default: mul_a = 17'(gz_reg);
                endcase
                mul_b = mul_a;
            end
            ST_F_MUL: begin
                mul_a = signed'({9'b0, coef});
                mul_b = diff;
            end
            ST_P_MUL: begin
                mul_a = (idx_reg == 2'd0) ? 17'(fay_reg) : 17'(faz_reg);
                mul_b = mul_a;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // ---------------- one-pole filter on the selected channel ---------------
    always_comb begin
        case (idx_reg)
            2'd0: begin
                cur_ext  = 17'(ax_reg);
                filt_ext = 17'(fax_reg);
                coef     = smoothing_reg;
                gate     = imec_pkg::ACCEL_GATE;
            end
            2'd1: begin
                cur_ext  = 17'(ay_reg);
                filt_ext = 17'(fay_reg);
                coef     = smoothing_reg;
                gate     = imec_pkg::ACCEL_GATE;
            end
            2'd2: begin
                cur_ext  = 17'(az_reg);
                filt_ext = 17'(faz_reg);
                coef     = smoothing_reg;
                gate     = imec_pkg::ACCEL_GATE;
            end
            default: begin
                cur_ext  = signed'({1'b0, gmag_reg});
                filt_ext = signed'({1'b0, frate_reg});
                coef     = imec_pkg::RATE_COEF;
                gate     = imec_pkg::RATE_GATE;
            end
        endcase
        diff      = cur_ext - filt_ext;
        gate_open = imec_pkg::abs17(diff) > gate;
        // divide by 256 truncating toward zero
        prod_adj  = prod_reg + (prod_reg[33] ? 34'sd255 : 34'sd0);
        prod_q    = prod_adj >>> 8;
        filt_new  = filt_ext + prod_q[16:0];
    end

    // ---------------- event tests ---------------------------------------
    always_comb begin
        abs_ax        = imec_pkg::abs17(17'(ax_reg));
        abs_ay        = imec_pkg::abs17(17'(ay_reg));
        abs_dz        = imec_pkg::abs17(17'(az_reg) - imec_pkg::ONE_G);
        tap_mag       = {1'b0, abs_ax} + {1'b0, abs_ay} + {1'b0, abs_dz};
        moving        = (abs_ax > {2'b0, still_limit_reg}) || (abs_ay > {2'b0, still_limit_reg})
                     || (abs_dz > {2'b0, vert_tol_reg}) || (frate_reg > imec_pkg::MOVE_RATE);
        since_sample  = time_reg - last_sample_reg;
        since_furious = time_reg - furious_begin_reg;
        since_shake   = time_reg - shake_begin_reg;
        since_tap     = time_reg - last_tap_reg;
        abs_pitch     = pitch_reg[imec_pkg::ANGLE_W-1] ? imec_pkg::ANGLE_W'(-pitch_reg)
                                                       : imec_pkg::ANGLE_W'(pitch_reg);
        abs_roll      = roll_reg[imec_pkg::ANGLE_W-1] ? imec_pkg::ANGLE_W'(-roll_reg)
                                                      : imec_pkg::ANGLE_W'(roll_reg);
    end

    // ---------------- shared units ----------------------------------------
    assign sqrt_start   = (state_reg == ST_GSTART) || (state_reg == ST_PSTART);
    assign cordic_start = (state_reg == ST_PITCH_GO) || (state_reg == ST_ROLL_GO);

    always_comb begin
        if (state_reg == ST_PITCH_GO) begin
            // pitch = atan2(-fx, sqrt(fy^2 + fz^2)), both scaled by 256
            cordic_y = -signed'({{3{fax_reg[15]}}, fax_reg, 8'b0});
            cordic_x = signed'({3'b0, sqrt_root, 8'b0});
        end else begin
            // roll = atan2(fy, fz), both scaled by 256
            cordic_y = signed'({{3{fay_reg[15]}}, fay_reg, 8'b0});
            cordic_x = signed'({{3{faz_reg[15]}}, faz_reg, 8'b0});
        end
    end

    imec_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (acc_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    imec_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .y_in    (cordic_y),
        .x_in    (cordic_x),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    // ---------------- configuration -----------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_limit_reg   <= imec_pkg::TILT_LIMIT_RST;
            angry_rate_reg   <= imec_pkg::ANGRY_RATE_RST;
            furious_rate_reg <= imec_pkg::FURIOUS_RATE_RST;
            tap_limit_reg    <= imec_pkg::TAP_LIMIT_RST;
            still_limit_reg  <= imec_pkg::STILL_LIMIT_RST;
            vert_tol_reg     <= imec_pkg::VERT_TOL_RST;
            smoothing_reg    <= imec_pkg::SMOOTHING_RST;
            tick_period_reg  <= imec_pkg::TICK_PERIOD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                imec_pkg::REG_TILT_LIMIT:   tilt_limit_reg   <= cfg_wdata[11:0];
                imec_pkg::REG_ANGRY_RATE:   angry_rate_reg   <= cfg_wdata[15:0];
                imec_pkg::REG_FURIOUS_RATE: furious_rate_reg <= cfg_wdata[15:0];
                imec_pkg::REG_TAP_LIMIT:    tap_limit_reg    <= cfg_wdata[16:0];
                imec_pkg::REG_STILL_LIMIT:  still_limit_reg  <= cfg_wdata[14:0];
                imec_pkg::REG_VERT_TOL:     vert_tol_reg     <= cfg_wdata[14:0];
                imec_pkg::REG_SMOOTHING:    smoothing_reg    <= cfg_wdata[7:0];
                imec_pkg::REG_TICK_PERIOD:  tick_period_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // product register carries payload only
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // ---------------- sequencer -------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            fax_reg            <= '0;
            fay_reg            <= '0;
            faz_reg            <= 16'sd4096;
            frate_reg          <= '0;
            shake_active_reg   <= 1'b0;
            furious_active_reg <= 1'b0;
            shake_begin_reg    <= '0;
            furious_begin_reg  <= '0;
            last_sample_reg    <= '0;
            last_tap_reg       <= '0;
            idx_reg            <= '0;
            evt_reg            <= imec_pkg::EVT_NONE;
            out_valid_reg      <= 1'b0;
        end else begin
            // drop the held result once the sink takes it; ST_FIN handles its own
            if (out_valid_reg && m_ready && state_reg != ST_FIN) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        time_reg <= s_time_ms;
                        ax_reg   <= s_accel_x;
                        ay_reg   <= s_accel_y;
                        az_reg   <= s_accel_z;
                        gx_reg   <= s_rate_x;
                        gy_reg   <= s_rate_y;
                        gz_reg   <= s_rate_z;
                        evt_reg  <= imec_pkg::EVT_NONE;
                        if (s_opcode) begin
                            // clear command: forget shake and tap history
                            shake_active_reg   <= 1'b0;
                            furious_active_reg <= 1'b0;
                            shake_begin_reg    <= '0;
                            furious_begin_reg  <= '0;
                            last_tap_reg       <= '0;
                            state_reg          <= ST_FIN;
                        end else begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end

                ST_CHECK: begin
                    // drop samples that come before a full tick has passed
                    if (since_sample < {16'b0, tick_period_reg}) begin
                        state_reg <= ST_FIN;
                    end else begin
                        last_sample_reg <= time_reg;
                        acc_reg         <= '0;
                        idx_reg         <= '0;
                        state_reg       <= ST_SQ_MUL;
                    end
                end

                ST_SQ_MUL: state_reg <= ST_SQ_ACC;

                ST_SQ_ACC: begin
                    acc_reg <= acc_reg + prod_reg[31:0];
                    if (idx_reg == 2'd2) begin
                        state_reg <= ST_GSTART;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_SQ_MUL;
                    end
                end

                ST_GSTART: state_reg <= ST_GROOT;

                ST_GROOT: begin
                    if (sqrt_done) begin
                        gmag_reg  <= sqrt_root;
                        idx_reg   <= '0;
                        state_reg <= ST_F_MUL;
                    end
                end

                ST_F_MUL: state_reg <= ST_F_UPD;

                ST_F_UPD: begin
                    if (gate_open) begin
                        case (idx_reg)
                            2'd0:    fax_reg   <= filt_new[15:0];
                            2'd1:    fay_reg   <= filt_new[15:0];
                            2'd2:    faz_reg   <= filt_new[15:0];
                            default: frate_reg <= filt_new[15:0];
                        endcase
                    end
                    idx_reg <= idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        state_reg <= ST_DECIDE;
                    end else begin
                        state_reg <= ST_F_MUL;
                    end
                end

                ST_DECIDE: begin
                    moving_reg <= moving;
                    acc_reg    <= '0;
                    idx_reg    <= '0;
                    state_reg  <= ST_P_MUL;
                    // shake tests: a held shake ends the step, otherwise fall to tap
                    if (frate_reg > furious_rate_reg) begin
                        if (!furious_active_reg) begin
                            furious_active_reg <= 1'b1;
                            furious_begin_reg  <= time_reg;
                        end
                    end else if (frate_reg > angry_rate_reg) begin
                        if (!shake_active_reg) begin
                            shake_active_reg <= 1'b1;
                            shake_begin_reg  <= time_reg;
                        end
                    end else begin
                        shake_active_reg   <= 1'b0;
                        furious_active_reg <= 1'b0;
                    end

                    if (frate_reg > furious_rate_reg && furious_active_reg
                            && since_furious > imec_pkg::FURIOUS_HOLD_MS) begin
                        evt_reg   <= imec_pkg::EVT_FURIOUS;
                        state_reg <= ST_FIN;
                    end else if (frate_reg <= furious_rate_reg && frate_reg > angry_rate_reg
                            && shake_active_reg && since_shake > imec_pkg::SHAKE_HOLD_MS) begin
                        evt_reg   <= imec_pkg::EVT_SHAKE;
                        state_reg <= ST_FIN;
                    end else if (tap_mag > {1'b0, tap_limit_reg}
                            && since_tap > imec_pkg::TAP_GAP_MS) begin
                        last_tap_reg <= time_reg;
                        evt_reg      <= imec_pkg::EVT_TAP;
                        state_reg    <= ST_FIN;
                    end
                end

                ST_P_MUL: state_reg <= ST_P_ACC;

                ST_P_ACC: begin
                    acc_reg <= acc_reg + prod_reg[31:0];
                    if (idx_reg == 2'd1) begin
                        state_reg <= ST_PSTART;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_P_MUL;
                    end
                end

                ST_PSTART: state_reg <= ST_PROOT;

                ST_PROOT: begin
                    if (sqrt_done) begin
                        state_reg <= ST_PITCH_GO;
                    end
                end

                ST_PITCH_GO: state_reg <= ST_PITCH;

                ST_PITCH: begin
                    if (cordic_done) begin
                        pitch_reg <= cordic_angle;
                        state_reg <= ST_ROLL_GO;
                    end
                end

                ST_ROLL_GO: state_reg <= ST_ROLL;

                ST_ROLL: begin
                    if (cordic_done) begin
                        roll_reg  <= cordic_angle;
                        state_reg <= ST_TILT;
                    end
                end

                ST_TILT: begin
                    if (abs_pitch > imec_pkg::ANGLE_W'(tilt_limit_reg)
                            || abs_roll > imec_pkg::ANGLE_W'(tilt_limit_reg)) begin
                        evt_reg <= imec_pkg::EVT_TILT;
                    end else if (!moving_reg) begin
                        evt_reg <= imec_pkg::EVT_STILL;
                    end else begin
                        evt_reg <= imec_pkg::EVT_NONE;
                    end
                    state_reg <= ST_FIN;
                end

                ST_FIN: begin
                    // hold until the output register is free, then load it
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_evt_reg   <= evt_reg;
                        out_x_reg     <= fax_reg;
                        out_y_reg     <= fay_reg;
                        out_z_reg     <= faz_reg;
                        out_rate_reg  <= frate_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_event_res   = out_evt_reg;
    assign m_smooth_x    = out_x_reg;
    assign m_smooth_y    = out_y_reg;
    assign m_smooth_z    = out_z_reg;
    assign m_smooth_rate = out_rate_reg;

endmodule

>>> hw/rtl/imec_isqrt.sv
// ----------------------------------------------------------------------------
// imec_isqrt
// Floor square root of a 32-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module imec_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] operand,
    output logic        done,
    output logic [15:0] root
);

    logic [31:0] n_reg;
    logic [17:0] rem_reg;
    logic [15:0] root_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [19:0] rem_shift;
    logic [19:0] trial;
    logic        take;

    assign rem_shift = {rem_reg, n_reg[31:30]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign take      = rem_shift >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                n_reg    <= operand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                n_reg    <= {n_reg[29:0], 2'b00};
                rem_reg  <= take ? 18'(rem_shift - trial) : rem_shift[17:0];
                root_reg <= {root_reg[14:0], take};
                cnt_reg  <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> hw/rtl/imec_cordic.sv
// ----------------------------------------------------------------------------
// imec_cordic
// Vectoring CORDIC atan2, one micro-rotation per cycle, angle in 1/16 degree.
// ----------------------------------------------------------------------------
module imec_cordic (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [imec_pkg::CORDIC_W-1:0] y_in,
    input  logic signed [imec_pkg::CORDIC_W-1:0] x_in,
    output logic                                 done,
    output logic signed [imec_pkg::ANGLE_W-1:0]  angle
);

    logic signed [imec_pkg::CORDIC_W-1:0] x_reg, y_reg;
    logic signed [imec_pkg::Z_W-1:0]      z_reg;
    logic signed [imec_pkg::ANGLE_W-1:0]  angle_reg;
    logic [3:0]                           i_reg;
    logic                                 busy_reg;
    logic                                 done_reg;

    logic signed [imec_pkg::CORDIC_W-1:0] dx, dy, x_step, y_step;
    logic signed [imec_pkg::Z_W-1:0]      arc, z_step, z_round;

    always_comb begin
        dx  = y_reg >>> i_reg;
        dy  = x_reg >>> i_reg;
        arc = imec_pkg::Z_W'(signed'({1'b0, imec_pkg::arc_of(i_reg)}));
        if (y_reg > 0) begin
            x_step = x_reg + dx;
            y_step = y_reg - dy;
            z_step = z_reg + arc;
        end else begin
            x_step = x_reg - dx;
            y_step = y_reg + dy;
            z_step = z_reg - arc;
        end
        z_round = (z_step + imec_pkg::Z_W'(128)) >>> 8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                i_reg <= '0;
                if (x_in == '0 && y_in == '0) begin
                    angle_reg <= '0;
                    done_reg  <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    if (x_in < 0) begin
                        // pre-rotate by half a turn into the right half plane
                        x_reg <= -x_in;
                        y_reg <= -y_in;
                        z_reg <= (y_in >= 0) ? imec_pkg::DEG180 : -imec_pkg::DEG180;
                    end else begin
                        x_reg <= x_in;
                        y_reg <= y_in;
                        z_reg <= '0;
                    end
                end
            end else if (busy_reg) begin
                x_reg <= x_step;
                y_reg <= y_step;
                z_reg <= z_step;
                i_reg <= i_reg + 4'd1;
                if (i_reg == 4'd15) begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    angle_reg <= z_round[imec_pkg::ANGLE_W-1:0];
                end
            end
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

>>> hw/rtl/imec_checker.sv
// ----------------------------------------------------------------------------
// imec_checker
// Port-level checks of the motion event classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "imu_motion_event_classifier_assert.svh"

module imec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_event_res,
    input logic [15:0] m_smooth_rate
);

    // a held result does not change under back-pressure
    `IMEC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_event_res) && $stable(m_smooth_rate))
    // the block is busy right after taking a transaction
    `IMEC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // still needs a quiet gyro filter
    `IMEC_ASSERT_IMPLY(a_still_quiet, m_valid && m_event_res == imec_pkg::EVT_STILL, m_smooth_rate <= imec_pkg::MOVE_RATE)
    // reset leaves no result pending and the input open
    `IMEC_ASSERT_RESET(a_reset_state, !aresetn, !m_valid && s_ready)

endmodule

bind imu_motion_event_classifier imec_checker u_imec_checker (.*);
